[hw/rtl/dedup_request_queue_dispatcher_macros.svh]
// Assertion helpers shared by the dispatcher.
`ifndef DEDUP_REQUEST_QUEUE_DISPATCHER_MACROS_SVH
`define DEDUP_REQUEST_QUEUE_DISPATCHER_MACROS_SVH

// Condition holds in the same cycle as its trigger.
`define DDQ_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// Condition holds in the cycle after its trigger.
`define DDQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

[hw/rtl/ddq_pkg.sv]
`default_nettype none
package ddq_pkg;

   localparam int EXTRUDERS     = 16;
   localparam int HISTORY_DEPTH = 8;
   localparam int LANES         = 4;
   localparam int GROUPS        = EXTRUDERS / LANES;

   localparam int ID_W       = $clog2(EXTRUDERS);
   localparam int CNT_W      = $clog2(EXTRUDERS + 1);
   localparam int LANE_W     = $clog2(LANES);
   localparam int GRP_W      = $clog2(GROUPS);
   localparam int NUM_W      = 5;
   localparam int HIST_IDX_W = 3;
   localparam int MASK_W     = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_MASK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_RECIPE = 2'd2;

   typedef logic [ID_W-1:0]       id_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [LANE_W-1:0]     lane_type;
   typedef logic [GRP_W-1:0]      grp_type;
   typedef logic [NUM_W-1:0]      num_type;
   typedef logic [EXTRUDERS-1:0]  vec_type;

   typedef struct packed {
      logic eligible;
      logic busy;
   } lane_out_type;

   typedef struct packed {
      logic                   append;
      logic                   dequeue;
      grp_type                grp;
      logic [LANES-1:0]       eligible;
   } queue_ctrl_type;

endpackage
`default_nettype wire

[hw/rtl/ddq_lane.sv]
`default_nettype none
// One scan lane: looks at a single extruder bit of the current group.
module ddq_lane (
   input  wire ddq_pkg::vec_type      req_bits,
   input  wire ddq_pkg::vec_type      busy_bits,
   input  wire ddq_pkg::vec_type      queued,
   input  wire ddq_pkg::grp_type      grp,
   input  wire ddq_pkg::lane_type     lane_sel,
   output ddq_pkg::lane_out_type      result
);

   ddq_pkg::id_type idx;

   assign idx             = ddq_pkg::id_type'({grp, lane_sel});
   assign result.eligible = req_bits[idx] & ~busy_bits[idx] & ~queued[idx];
   assign result.busy     = busy_bits[idx];

endmodule
`default_nettype wire

[hw/rtl/ddq_queue.sv]
`default_nettype none
// Deduplicated FIFO of extruder numbers. Appends merge the lane results in
// ascending bit order; the queued mask tracks which extruders are present.
module ddq_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire ddq_pkg::queue_ctrl_type ctrl,
   output ddq_pkg::cnt_type           len,
   output ddq_pkg::id_type            head,
   output ddq_pkg::vec_type           queued
);

   ddq_pkg::id_type  slots_ff [ddq_pkg::EXTRUDERS];
   ddq_pkg::id_type  slots_in [ddq_pkg::EXTRUDERS];
   ddq_pkg::cnt_type len_ff;
   ddq_pkg::cnt_type len_in;
   ddq_pkg::vec_type queued_ff;
   ddq_pkg::vec_type queued_in;

   always_comb begin
      ddq_pkg::id_type id;
      id        = '0;
      slots_in  = slots_ff;
      len_in    = len_ff;
      queued_in = queued_ff;
      if (ctrl.append) begin
         for (int k = 0; k < ddq_pkg::LANES; k++) begin
            id = ddq_pkg::id_type'({ctrl.grp, ddq_pkg::lane_type'(k)});
            if (ctrl.eligible[k] && len_in < ddq_pkg::cnt_type'(ddq_pkg::EXTRUDERS)) begin
               slots_in[len_in[ddq_pkg::ID_W-1:0]] = id;
               queued_in[id] = 1'b1;
               len_in = len_in + ddq_pkg::cnt_type'(1);
            end
         end
      end else if (ctrl.dequeue) begin
         for (int i = 0; i < ddq_pkg::EXTRUDERS - 1; i++) begin
            slots_in[i] = slots_ff[i + 1];
         end
         queued_in[slots_ff[0]] = 1'b0;
         len_in = len_ff - ddq_pkg::cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         len_ff    <= '0;
         queued_ff <= '0;
      end else begin
         len_ff    <= len_in;
         queued_ff <= queued_in;
      end
   end

   assign len    = len_ff;
   assign head   = slots_ff[0];
   assign queued = queued_ff;

endmodule
`default_nettype wire

[hw/rtl/dedup_request_queue_dispatcher.sv]
// Flow: in single mode an accepted transaction scans the four groups in ST_SCAN,
// then passes through ST_DISPATCH and ST_DONE, which registers the result once the
// response slot is free. Outside single mode it goes from ST_IDLE straight to ST_DONE.
// A new transaction is accepted only in ST_IDLE, after the last result is issued; the
// four lanes scan one group of four extruder bits per cycle.
// Reset (synchronous, active high) empties the queue and history, clears a pending clear.
`default_nettype none
`include "dedup_request_queue_dispatcher_macros.svh"
module dedup_request_queue_dispatcher (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire [15:0]                       req_request_bits,
   input  wire [15:0]                       req_busy_bits,
   input  wire                              req_recipe_waiting,
   input  wire                              req_paused,
   input  wire                              req_clear_request,
   input  wire [2:0]                        req_history_index,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic                             rsp_start_valid,
   output logic [4:0]                       rsp_start_number,
   output logic [4:0]                       rsp_queue_count,
   output logic [3:0]                       rsp_selected_extruder,
   output logic [4:0]                       rsp_history_entry,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [ddq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [15:0]                       csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DISPATCH, ST_DONE} state_type;

   state_type                       state_ff, state_in;
   ddq_pkg::grp_type                grp_ff, grp_in;
   ddq_pkg::vec_type                req_bits_ff, req_bits_in;
   ddq_pkg::vec_type                busy_bits_ff, busy_bits_in;
   logic                            waiting_ff, waiting_in;
   logic                            paused_ff, paused_in;
   logic [ddq_pkg::HIST_IDX_W-1:0]  hidx_ff, hidx_in;
   logic                            any_busy_ff, any_busy_in;
   logic                            start_ff, start_in;
   ddq_pkg::num_type                number_ff, number_in;
   ddq_pkg::id_type                 head_ff, head_in;
   ddq_pkg::num_type                history_ff [ddq_pkg::HISTORY_DEPTH];
   ddq_pkg::num_type                history_in [ddq_pkg::HISTORY_DEPTH];
   logic                            clear_pending_ff, clear_pending_in;
   logic                            single_mode_ff, single_mode_in;
   logic [ddq_pkg::MASK_W-1:0]      enable_ff, enable_in;
   logic [ddq_pkg::MASK_W-1:0]      empty_ff, empty_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_start_valid_ff, rsp_start_valid_in;
   ddq_pkg::num_type                rsp_start_number_ff, rsp_start_number_in;
   ddq_pkg::cnt_type                rsp_queue_count_ff, rsp_queue_count_in;
   ddq_pkg::id_type                 rsp_selected_ff, rsp_selected_in;
   ddq_pkg::num_type                rsp_history_ff, rsp_history_in;

   ddq_pkg::lane_out_type           lane_out [ddq_pkg::LANES];
   ddq_pkg::queue_ctrl_type         q_ctrl;
   ddq_pkg::cnt_type                q_len;
   ddq_pkg::id_type                 q_head;
   ddq_pkg::vec_type                q_queued;
   logic                            lanes_busy;
   logic                            go;
   logic                            start_now;
   logic                            req_accept;
   logic                            rsp_free;

   for (genvar k = 0; k < ddq_pkg::LANES; k++) begin : g_lane
      ddq_lane u_lane (
         .req_bits  (req_bits_ff),
         .busy_bits (busy_bits_ff),
         .queued    (q_queued),
         .grp       (grp_ff),
         .lane_sel  (ddq_pkg::lane_type'(k)),
         .result    (lane_out[k])
      );
      assign q_ctrl.eligible[k] = lane_out[k].eligible;
   end

   always_comb begin
      lanes_busy = 1'b0;
      for (int k = 0; k < ddq_pkg::LANES; k++) begin
         lanes_busy = lanes_busy | lane_out[k].busy;
      end
   end

   // Dispatch is blocked while anything is busy; the head is dequeued even
   // when its start is suppressed.
   assign go        = (q_len != '0) && !waiting_ff && !paused_ff && !any_busy_ff;
   assign start_now = go && enable_ff[q_head] && !empty_ff[q_head] && req_bits_ff[q_head];

   assign q_ctrl.append  = (state_ff == ST_SCAN);
   assign q_ctrl.dequeue = (state_ff == ST_DISPATCH) && go;
   assign q_ctrl.grp     = grp_ff;

   ddq_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (q_ctrl),
      .len    (q_len),
      .head   (q_head),
      .queued (q_queued)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in            = state_ff;
      grp_in              = grp_ff;
      req_bits_in         = req_bits_ff;
      busy_bits_in        = busy_bits_ff;
      waiting_in          = waiting_ff;
      paused_in           = paused_ff;
      hidx_in             = hidx_ff;
      any_busy_in         = any_busy_ff;
      start_in            = start_ff;
      number_in           = number_ff;
      head_in             = head_ff;
      history_in          = history_ff;
      clear_pending_in    = clear_pending_ff;
      single_mode_in      = single_mode_ff;
      enable_in           = enable_ff;
      empty_in            = empty_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_start_valid_in  = rsp_start_valid_ff;
      rsp_start_number_in = rsp_start_number_ff;
      rsp_queue_count_in  = rsp_queue_count_ff;
      rsp_selected_in     = rsp_selected_ff;
      rsp_history_in      = rsp_history_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            ddq_pkg::CSR_SINGLE_MODE:  single_mode_in = csr_data[0];
            ddq_pkg::CSR_ENABLE_MASK:  enable_in      = csr_data;
            ddq_pkg::CSR_EMPTY_RECIPE: empty_in       = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_bits_in  = req_request_bits;
               busy_bits_in = req_busy_bits;
               waiting_in   = req_recipe_waiting;
               paused_in    = req_paused;
               hidx_in      = req_history_index;
               start_in     = 1'b0;
               number_in    = '0;
               any_busy_in  = 1'b0;
               grp_in       = '0;
               // A clear request stays pending until a transaction runs in single mode.
               if (single_mode_ff) begin
                  if (clear_pending_ff || req_clear_request) begin
                     for (int i = 0; i < ddq_pkg::HISTORY_DEPTH; i++) begin
                        history_in[i] = '0;
                     end
                  end
                  clear_pending_in = 1'b0;
                  state_in         = ST_SCAN;
               end else begin
                  clear_pending_in = clear_pending_ff | req_clear_request;
                  state_in         = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            any_busy_in = any_busy_ff | lanes_busy;
            grp_in      = grp_ff + ddq_pkg::grp_type'(1);
            if (grp_ff == ddq_pkg::grp_type'(ddq_pkg::GROUPS - 1)) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (q_len != '0) begin
               head_in = q_head;
            end
            if (start_now) begin
               start_in  = 1'b1;
               number_in = ddq_pkg::num_type'(q_head) + ddq_pkg::num_type'(1);
               for (int i = ddq_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
                  history_in[i] = history_ff[i - 1];
               end
               history_in[0] = ddq_pkg::num_type'(q_head) + ddq_pkg::num_type'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_start_valid_in  = start_ff;
               rsp_start_number_in = number_ff;
               rsp_queue_count_in  = q_len;
               rsp_selected_in     = head_ff;
               rsp_history_in      = history_ff[hidx_ff];
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      grp_ff              <= grp_in;
      req_bits_ff         <= req_bits_in;
      busy_bits_ff        <= busy_bits_in;
      waiting_ff          <= waiting_in;
      paused_ff           <= paused_in;
      hidx_ff             <= hidx_in;
      any_busy_ff         <= any_busy_in;
      number_ff           <= number_in;
      rsp_start_valid_ff  <= rsp_start_valid_in;
      rsp_start_number_ff <= rsp_start_number_in;
      rsp_queue_count_ff  <= rsp_queue_count_in;
      rsp_selected_ff     <= rsp_selected_in;
      rsp_history_ff      <= rsp_history_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         start_ff         <= 1'b0;
         head_ff          <= '0;
         clear_pending_ff <= 1'b0;
         single_mode_ff   <= 1'b1;
         enable_ff        <= '0;
         empty_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < ddq_pkg::HISTORY_DEPTH; i++) begin
            history_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         start_ff         <= start_in;
         head_ff          <= head_in;
         clear_pending_ff <= clear_pending_in;
         single_mode_ff   <= single_mode_in;
         enable_ff        <= enable_in;
         empty_ff         <= empty_in;
         rsp_valid_ff     <= rsp_valid_in;
         history_ff       <= history_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_start_valid       = rsp_start_valid_ff;
   assign rsp_start_number      = rsp_start_number_ff;
   assign rsp_queue_count       = rsp_queue_count_ff;
   assign rsp_selected_extruder = rsp_selected_ff;
   assign rsp_history_entry     = rsp_history_ff;

   `DDQ_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, q_len <= ddq_pkg::cnt_type'(ddq_pkg::EXTRUDERS), "queue length exceeds extruder count")
   `DDQ_ASSERT_NOW(a_mask_matches_len, clock, reset, 1'b1, $countones(q_queued) == q_len, "queued mask disagrees with queue length")
   `DDQ_ASSERT_NOW(a_start_number, clock, reset, rsp_valid_ff && rsp_start_valid_ff, rsp_start_number_ff != '0, "start issued without a number")
   `DDQ_ASSERT_NEXT(a_result_issued, clock, reset, (state_ff == ST_DONE) && rsp_free, rsp_valid_ff && (state_ff == ST_IDLE), "finished transaction not presented")

endmodule
`default_nettype wire
